// ===== sv/lag_pkg.sv =====
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types and constants of the life automaton grid: item structs,
// command and register codes, lane geometry and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lag_pkg;

  localparam int ROW_W  = 64;
  localparam int LANES  = 4;
  localparam int LANE_W = ROW_W / LANES;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_GENS   = 2'd2;

  localparam logic [6:0]  WIDTH_RST  = 7'd64;
  localparam logic [6:0]  HEIGHT_RST = 7'd64;
  localparam logic [15:0] GENS_RST   = 16'd1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [5:0]       row_index;
    logic [ROW_W-1:0] row_cells;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_data;
    logic             index_error;
  } out_item_t;

  // three-row window slice for one lane, one guard column on each side
  typedef struct packed {
    logic [LANE_W+1:0] up;
    logic [LANE_W+1:0] cur;
    logic [LANE_W+1:0] down;
  } lane_win_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PRIME,
    ST_LOAD,
    ST_SWEEP
  } lag_state_e;

endpackage

`default_nettype wire

// ===== sv/lag_row_mem.sv =====
// ----------------------------------------------------------------------------
// lag_row_mem
// Row store of the cell grid: one write port, one registered read port, and
// a valid bit per row so that rows never written read as all dead.
// ----------------------------------------------------------------------------
`default_nettype none

module lag_row_mem
  import lag_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [ROW_W-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [ROW_W-1:0] rdata_o
);

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [ROW_W-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== sv/lag_lane.sv =====
// ----------------------------------------------------------------------------
// lag_lane
// One lane of the generation step: counts the eight neighbours of each cell
// in its slice and applies the birth-on-three, survive-on-two-or-three rule.
// ----------------------------------------------------------------------------
`default_nettype none

module lag_lane
  import lag_pkg::*;
(
  input  wire lane_win_t         win_i,
  output logic      [LANE_W-1:0] next_o
);

  always_comb begin
    logic [3:0] cnt;
    for (int i = 0; i < LANE_W; i++) begin
      cnt = 4'(win_i.up[i])   + 4'(win_i.up[i+1])   + 4'(win_i.up[i+2]) +
            4'(win_i.cur[i])                        + 4'(win_i.cur[i+2]) +
            4'(win_i.down[i]) + 4'(win_i.down[i+1]) + 4'(win_i.down[i+2]);
      next_o[i] = (cnt == 4'd3) || ((cnt == 4'd2) && win_i.cur[i+1]);
    end
  end

endmodule

`default_nettype wire

// ===== sv/lag_merge.sv =====
// ----------------------------------------------------------------------------
// lag_merge
// Joins the lane results into one row word and clears the columns beyond the
// grid width.
// ----------------------------------------------------------------------------
`default_nettype none

module lag_merge
  import lag_pkg::*;
(
  input  wire logic [LANES-1:0][LANE_W-1:0] lanes_i,
  input  wire logic [ROW_W-1:0]             mask_i,
  output logic      [ROW_W-1:0]             row_o
);

  assign row_o = lanes_i & mask_i;

endmodule

`default_nettype wire

// ===== sv/life_automaton_grid.sv =====
// ----------------------------------------------------------------------------
// life_automaton_grid
// Bounded Game of Life engine (B3/S23) on a grid of up to 64 by 64 cells.
// ----------------------------------------------------------------------------
// The grid lives in a row memory, one 64-bit word per row, bit x being
// column x; cells outside the configured width and height count as dead.
// Every accepted item gives exactly one result item. Write and unused
// commands, and a read of a row outside the grid, answer straight from the
// result register; a read in range first passes the registered memory read.
// A run command answers at once when generation_count is zero; else each
// generation sweeps the rows once through a three-row window, one row per
// cycle, paced by the single read port of the row memory, after the PRIME
// and LOAD states have filled the window. The next row is worked out by
// four lanes of 16 columns side by side and merged into one word that is
// written back the same cycle. Items are taken one at a time; a new item is
// accepted while the previous result is being taken. After reset all cells
// read as dead at once: per-row valid bits stand in for a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_grid
  import lag_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // command items
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_i,
  // result items
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_o,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int         AW       = $clog2(MAX_SIDE);
  localparam logic [6:0] SIDE_MAX = 7'(MAX_SIDE);

  // configuration registers
  logic [6:0]  width_q;
  logic [6:0]  height_q;
  logic [15:0] gens_q;

  // sequencer and datapath state
  lag_state_e       state_q, state_d;
  logic [AW-1:0]    cursor_q, cursor_d;
  logic [15:0]      gens_left_q, gens_left_d;
  logic [ROW_W-1:0] up_q, up_d;
  logic [ROW_W-1:0] cur_q, cur_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  // memory port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [ROW_W-1:0] rd_row;

  // derived values
  logic [6:0]       eff_w, eff_h;
  logic [ROW_W-1:0] wmask;
  logic             in_range;
  logic             accept;
  logic [6:0]       cursor7, nx1, nx2;
  logic             down_ok, nx2_ok;
  logic [ROW_W-1:0] rd_masked, down_row, new_row;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      gens_q   <= GENS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[6:0];
        CFG_HEIGHT: height_q <= cfg_data_i[6:0];
        CFG_GENS:   gens_q   <= cfg_data_i;
        default:    ;  // unknown register, ignored
      endcase
    end
  end

  // zero counts as one, anything above the grid side is clamped
  always_comb begin
    if (width_q == 7'd0)          eff_w = 7'd1;
    else if (width_q > SIDE_MAX)  eff_w = SIDE_MAX;
    else                          eff_w = width_q;
    if (height_q == 7'd0)         eff_h = 7'd1;
    else if (height_q > SIDE_MAX) eff_h = SIDE_MAX;
    else                          eff_h = height_q;
  end

  // columns in use
  always_comb begin
    for (int x = 0; x < ROW_W; x++) begin
      wmask[x] = 7'(x) < eff_w;
    end
  end

  assign in_range = {1'b0, in_i.row_index} < eff_h;
  assign accept   = in_valid_i && in_ready_o;

  // sweep bookkeeping: row below the cursor and the row to fetch next
  assign cursor7 = 7'(cursor_q);
  assign nx1     = cursor7 + 7'd1;
  assign nx2     = cursor7 + 7'd2;
  assign down_ok = nx1 < eff_h;
  assign nx2_ok  = nx2 < eff_h;

  assign rd_masked = rd_row & wmask;
  assign down_row  = down_ok ? rd_masked : '0;

  // ---------------------------------------------------------------------
  // row memory
  // ---------------------------------------------------------------------
  lag_row_mem #(
    .DEPTH (MAX_SIDE),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_row)
  );

  // ---------------------------------------------------------------------
  // generation lanes and merge
  // ---------------------------------------------------------------------
  logic [ROW_W+1:0]              up_pad, cur_pad, down_pad;
  logic [LANES-1:0][LANE_W-1:0]  lane_next;

  // one dead guard column on each side of the row
  assign up_pad   = {1'b0, up_q,     1'b0};
  assign cur_pad  = {1'b0, cur_q,    1'b0};
  assign down_pad = {1'b0, down_row, 1'b0};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lane_win_t win;
    assign win.up   = up_pad[l*LANE_W +: LANE_W+2];
    assign win.cur  = cur_pad[l*LANE_W +: LANE_W+2];
    assign win.down = down_pad[l*LANE_W +: LANE_W+2];

    lag_lane u_lane (
      .win_i  (win),
      .next_o (lane_next[l])
    );
  end

  lag_merge u_merge (
    .lanes_i (lane_next),
    .mask_i  (wmask),
    .row_o   (new_row)
  );

  // ---------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.cmd == CMD_READ && in_range) begin
            state_d = ST_READ;
          end else if (in_i.cmd == CMD_RUN && gens_q != 16'd0) begin
            state_d = ST_PRIME;
          end
        end
      end
      ST_READ:  state_d = ST_IDLE;
      ST_PRIME: state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_SWEEP;
      ST_SWEEP: begin
        // last row of the generation
        if (!down_ok) begin
          state_d = (gens_left_q == 16'd1) ? ST_IDLE : ST_PRIME;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer: handshake and memory control
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;
    case (state_q)
      ST_IDLE: begin
        // result register is free or emptied this cycle
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_range) begin
          if (in_i.cmd == CMD_WRITE) begin
            mem_we    = in_ready_o;
            mem_waddr = AW'(in_i.row_index);
            mem_wdata = in_i.row_cells & wmask;
          end
          mem_raddr = AW'(in_i.row_index);
        end
      end
      ST_PRIME: mem_raddr = '0;
      ST_LOAD:  mem_raddr = (eff_h > 7'd1) ? AW'(1) : '0;
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cursor_q;
        mem_wdata = new_row;
        mem_raddr = nx2_ok ? AW'(nx2) : '0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath next values
  // ---------------------------------------------------------------------
  always_comb begin
    cursor_d    = cursor_q;
    gens_left_d = gens_left_q;
    up_d        = up_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d.row_data    = '0;
          out_d.index_error = 1'b0;
          case (in_i.cmd)
            CMD_WRITE: begin
              out_d.index_error = !in_range;
              out_valid_d       = 1'b1;
            end
            CMD_RUN: begin
              gens_left_d = gens_q;
              // zero generations: grid untouched, answer at once
              out_valid_d = (gens_q == 16'd0);
            end
            CMD_READ: begin
              out_d.index_error = !in_range;
              out_valid_d       = !in_range;
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        out_d.row_data    = rd_masked;
        out_d.index_error = 1'b0;
        out_valid_d       = 1'b1;
      end
      ST_PRIME: ;
      ST_LOAD: begin
        up_d     = '0;
        cur_d    = rd_masked;
        cursor_d = '0;
      end
      ST_SWEEP: begin
        up_d  = cur_q;
        cur_d = down_row;
        if (!down_ok) begin
          cursor_d    = '0;
          gens_left_d = gens_left_q - 16'd1;
          if (gens_left_q == 16'd1) begin
            out_d.row_data    = '0;
            out_d.index_error = 1'b0;
            out_valid_d       = 1'b1;
          end
        end else begin
          cursor_d = AW'(nx1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      gens_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      gens_left_q <= gens_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    up_q  <= up_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== sim/life_automaton_grid_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_grid_checker
// Watches the command, result and register ports of the life grid, keeps a
// shadow grid that it advances itself, and compares every result item with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module life_automaton_grid_checker
  import lag_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int GRID_SIDE = 64;

  logic [6:0]       width_reg;
  logic [6:0]       height_reg;
  logic [15:0]      gens_reg;
  logic [ROW_W-1:0] grid_rows [GRID_SIDE];
  out_item_t        expected_results [$];
  int               row_nr;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // zero counts as one, anything above the grid side as the full side
  function automatic int side_in_use(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > GRID_SIDE) return GRID_SIDE;
    return int'(v);
  endfunction

  function automatic logic [ROW_W-1:0] column_mask(logic [6:0] w);
    int cols;
    cols = side_in_use(w);
    if (cols >= ROW_W) return '1;
    return (64'd1 << cols) - 64'd1;
  endfunction

  // bit-sliced neighbor count per column: ones, twos, and a sticky four-or-more
  function automatic logic [ROW_W-1:0] life_next_row(logic [ROW_W-1:0] above,
                                                     logic [ROW_W-1:0] here,
                                                     logic [ROW_W-1:0] below,
                                                     logic [ROW_W-1:0] mask);
    logic [ROW_W-1:0] ones, twos, fours, carry, nb;
    int k;
    ones  = '0;
    twos  = '0;
    fours = '0;
    for (k = 0; k < 8; k++) begin
      case (k)
        0: nb = (above << 1) & mask;
        1: nb = above;
        2: nb = above >> 1;
        3: nb = (here << 1) & mask;
        4: nb = here >> 1;
        5: nb = (below << 1) & mask;
        6: nb = below;
        default: nb = below >> 1;
      endcase
      carry = ones & nb;
      ones  = ones ^ nb;
      fours = fours | (twos & carry);
      twos  = twos ^ carry;
    end
    // born on three, survives on two or three
    return twos & ~fours & (ones | here) & mask;
  endfunction

  task automatic advance_grid();
    int rows, g, r;
    logic [ROW_W-1:0] mask, above, here, below;
    rows = side_in_use(height_reg);
    mask = column_mask(width_reg);
    for (g = 0; g < int'(gens_reg); g++) begin
      above = '0;
      here  = grid_rows[0] & mask;
      for (r = 0; r < rows; r++) begin
        below = (r + 1 < rows) ? (grid_rows[r + 1] & mask) : '0;
        grid_rows[r] = life_next_row(above, here, below, mask);
        above = here;
        here  = below;
      end
    end
  endtask

  task automatic predict_result(in_item_t item);
    out_item_t res;
    int rows;
    logic [ROW_W-1:0] mask;
    rows = side_in_use(height_reg);
    mask = column_mask(width_reg);
    res  = '0;
    case (item.cmd)
      CMD_WRITE: begin
        if (int'(item.row_index) < rows) grid_rows[item.row_index] = item.row_cells & mask;
        else res.index_error = 1'b1;
      end
      CMD_RUN: begin
        advance_grid();
      end
      CMD_READ: begin
        if (int'(item.row_index) < rows) res.row_data = grid_rows[item.row_index] & mask;
        else res.index_error = 1'b1;
      end
      default: begin
      end
    endcase
    expected_results.push_back(res);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      fail_count_o++;
      $display("%0t: unexpected result, expected none, actual row_data %h index_error %b",
               $time, got.row_data, got.index_error);
    end else begin
      want = expected_results.pop_front();
      if (got.row_data !== want.row_data) begin
        fail_count_o++;
        $display("%0t: row_data expected %h actual %h", $time, want.row_data, got.row_data);
      end
      if (got.index_error !== want.index_error) begin
        fail_count_o++;
        $display("%0t: index_error expected %b actual %b", $time, want.index_error,
                 got.index_error);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      gens_reg   = GENS_RST;
      for (row_nr = 0; row_nr < GRID_SIDE; row_nr++) grid_rows[row_nr] = '0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      // results first: an item taken at this edge cannot answer at it
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (in_valid_i && in_ready_i) predict_result(in_item_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WIDTH:  width_reg  = cfg_data_i[6:0];
          CFG_HEIGHT: height_reg = cfg_data_i[6:0];
          CFG_GENS:   gens_reg   = cfg_data_i;
          default: begin
          end
        endcase
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== sim/life_automaton_grid_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_automaton_grid_tb
// Drives command items and register writes into the life grid engine, with
// random idle bursts on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module life_automaton_grid_tb;
  import lag_pkg::*;

  // command with no effect, and a register index past the end of the list
  localparam logic [1:0] CMD_NOP    = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int NUM_PHASES      = 12;
  localparam int FIXED_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 155;
  // limit well above the slowest run, including the 65535 generation run
  localparam int CYCLE_LIMIT     = 3_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [15:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int ready_hold  = 0;
  bit idle_on     = 1'b1;

  // per-phase register settings
  logic [6:0]  phase_w [NUM_PHASES];
  logic [6:0]  phase_h [NUM_PHASES];
  logic [15:0] phase_g [NUM_PHASES];

  life_automaton_grid dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  life_automaton_grid_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side backpressure: random low bursts while idling is on
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(logic [1:0] cmd, logic [5:0] idx, logic [ROW_W-1:0] cells);
    in_item_t item;
    item.cmd       = cmd;
    item.row_index = idx;
    item.row_cells = cells;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // drop valid and wait until every outstanding result has come back
  task automatic settle_grid();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // width and height carry junk above bit 6, which the block has to drop
  task automatic set_grid_config(logic [6:0] w, logic [6:0] h, logic [15:0] g);
    write_reg(CFG_WIDTH, {9'($urandom), w});
    write_reg(CFG_HEIGHT, {9'($urandom), h});
    write_reg(CFG_GENS, g);
    write_reg(CFG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int p, n, pick, h_eff;
    logic [1:0]       cmd;
    logic [5:0]       idx;
    logic [ROW_W-1:0] cells;

    // fixed settings: zero sizes, oversize sizes, single column and row,
    // zero generations, full grid, and a few odd shapes
    phase_w[0] = 7'd0;   phase_h[0] = 7'd0;   phase_g[0] = 16'd3;
    phase_w[1] = 7'd127; phase_h[1] = 7'd127; phase_g[1] = 16'd2;
    phase_w[2] = 7'd1;   phase_h[2] = 7'd64;  phase_g[2] = 16'd4;
    phase_w[3] = 7'd64;  phase_h[3] = 7'd1;   phase_g[3] = 16'd9;
    phase_w[4] = 7'd65;  phase_h[4] = 7'd2;   phase_g[4] = 16'd0;
    phase_w[5] = 7'd64;  phase_h[5] = 7'd64;  phase_g[5] = 16'd5;
    phase_w[6] = 7'd33;  phase_h[6] = 7'd17;  phase_g[6] = 16'd6;
    phase_w[7] = 7'd8;   phase_h[7] = 7'd8;   phase_g[7] = 16'd12;
    for (p = FIXED_PHASES; p < NUM_PHASES; p++) begin
      phase_w[p] = 7'($urandom_range(1, 64));
      phase_h[p] = 7'($urandom_range(1, 64));
      // scale the generation count down with the height to keep each run short
      phase_g[p] = 16'($urandom_range(0, 600 / (int'(phase_h[p]) + 2)));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset grid: all dead, full 64 by 64, one generation per run
    send_item(CMD_READ, 6'd0, '0);
    send_item(CMD_READ, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_WRITE, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_WRITE, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(CMD_WRITE, 6'd1, 64'h5555_5555_5555_5555);
    send_item(CMD_READ, 6'd0, '0);
    send_item(CMD_READ, 6'd63, '0);
    send_item(CMD_NOP, 6'($urandom), {$urandom, $urandom});
    send_item(CMD_RUN, 6'($urandom), {$urandom, $urandom});
    send_item(CMD_READ, 6'd0, '0);
    send_item(CMD_READ, 6'd1, '0);
    send_item(CMD_READ, 6'd2, '0);
    send_item(CMD_READ, 6'd62, '0);
    send_item(CMD_READ, 6'd63, '0);
    settle_grid();

    // 3 by 3 blinker, junk above the width, odd maximum generation count:
    // ends in the horizontal phase
    set_grid_config(7'd3, 7'd3, 16'hFFFF);
    send_item(CMD_WRITE, 6'd0, 64'hFFFF_FFFF_FFFF_FFF2);
    send_item(CMD_WRITE, 6'd1, 64'h8000_0000_0000_0002);
    send_item(CMD_WRITE, 6'd2, 64'h0F0F_0F0F_0F0F_0F0A);
    send_item(CMD_WRITE, 6'd3, 64'h7);
    send_item(CMD_RUN, 6'd0, '0);
    send_item(CMD_READ, 6'd0, '0);
    send_item(CMD_READ, 6'd1, '0);
    send_item(CMD_READ, 6'd5, '0);
    settle_grid();

    // zero generations leaves the grid alone
    set_grid_config(7'd3, 7'd3, 16'd0);
    send_item(CMD_RUN, 6'd1, '0);
    send_item(CMD_READ, 6'd1, '0);
    settle_grid();

    // random phases: mostly row writes and reads in range, some runs
    for (p = 0; p < NUM_PHASES; p++) begin
      h_eff = (phase_h[p] == 7'd0) ? 1 : (phase_h[p] > 7'd64 ? 64 : int'(phase_h[p]));
      set_grid_config(phase_w[p], phase_h[p], phase_g[p]);
      // one calm phase in four, and none at all in the last one
      idle_on = (p < NUM_PHASES - 1) && (p % 4 != 2);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) cmd = CMD_WRITE;
        else if (pick < 85) cmd = CMD_READ;
        else if (pick < 93) cmd = CMD_RUN;
        else cmd = CMD_NOP;
        if ($urandom_range(0, 4) == 0) idx = 6'($urandom_range(0, 63));
        else idx = 6'($urandom_range(0, h_eff - 1));
        // sparse, even and dense rows so the patterns both die and grow
        case ($urandom_range(0, 2))
          0: cells = {$urandom, $urandom} & {$urandom, $urandom};
          1: cells = {$urandom, $urandom};
          default: cells = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
        send_item(cmd, idx, cells);
        if (idle_on && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 8));
      end
      settle_grid();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
